### rtl/mbp_pkg.sv
// Shared widths, request codes and divider result type for the bitmap page converter.
`timescale 1ns / 1ps

package mbp_pkg;

	// Fixed field widths of the request and response channels
	localparam int TYPE_W = 1;
	localparam int ROW_W  = 6;
	localparam int BYTE_W = 5;
	localparam int DATA_W = 8;
	localparam int IDX_W  = 10;

	// Request type codes
	localparam logic [TYPE_W-1:0] REQ_WRITE = 1'b0;
	localparam logic [TYPE_W-1:0] REQ_READ  = 1'b1;

	// First byte of the panel message
	localparam logic [DATA_W-1:0] HEADER_MAGIC = 8'h03;

	// Band and column of a message byte, handed back by the divider
	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] quot;
		logic [IDX_W-1:0] rem;
	} div_res_t;

endpackage

### rtl/mbp_if.sv
// Request and response channel interfaces of the bitmap page converter.
`timescale 1ns / 1ps

interface mbp_req_if;
	import mbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [ROW_W-1:0]  src_row;
	logic [BYTE_W-1:0] src_byte;
	logic [DATA_W-1:0] src_data;
	logic [IDX_W-1:0]  out_index;

	modport source (
		output valid, req_type, src_row, src_byte, src_data, out_index,
		input  ready
	);

	modport sink (
		input  valid, req_type, src_row, src_byte, src_data, out_index,
		output ready
	);
endinterface

interface mbp_rsp_if;
	import mbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_byte;
	logic [IDX_W-1:0]  out_position;

	modport source (
		output valid, out_byte, out_position,
		input  ready
	);

	modport sink (
		input  valid, out_byte, out_position,
		output ready
	);
endinterface

### rtl/mono_bitmap_to_page_bytes.sv
// Top level: row-major pixel frame store with vertical page byte read-out.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, src_row, src_byte, src_data, out_index
//   rsp      out  valid/ready   out_byte, out_position
//
// Writes are stored in ST_WR; header and out-of-range reads go straight to
// ST_DONE to load the response. A pixel read splits the offset into band
// and column in the divider, forms the band address in ST_BASE, reads the
// single-port frame store eight times in ST_GATHER and responds from ST_DONE.
// Reset clears control only; the store holds garbage until written.
// A response waiting on rsp does not block the next request; a finished
// read waits in place until the response register is free.
`timescale 1ns / 1ps

module mono_bitmap_to_page_bytes #(
	parameter int COLUMNS      = 160,
	parameter int ROWS         = 43,
	parameter int HEADER_BYTES = 32,
	parameter int OUTPUT_BYTES = 992
) (
	input  logic      clk,
	input  logic      arst_n,
	mbp_req_if.sink   req,
	mbp_rsp_if.source rsp
);
	import mbp_pkg::*;

	localparam int ROW_BYTES = (COLUMNS + 7) / 8;
	localparam int DEPTH     = ROWS * ROW_BYTES;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RB_W      = IDX_W + 3;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WR     = 6'b000010,
		ST_DIV    = 6'b000100,
		ST_BASE   = 6'b001000,
		ST_GATHER = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t            state_q;

	// Frame store
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [AW-1:0]     mem_addr;
	logic              mem_we;

	// Write request
	logic              wr_ok_q;
	logic [AW-1:0]     wr_addr_q;
	logic [DATA_W-1:0] wr_data_q;

	// Read request
	logic [IDX_W-1:0]  idx_q;
	logic [DATA_W-1:0] acc_q;
	logic [RB_W-1:0]   row_base_q;
	logic [AW-1:0]     addr_q;
	logic [2:0]        bit_q;
	logic [3:0]        iss_q;
	logic              rd_vld_s1;
	logic [2:0]        rd_r_s1;
	logic              rd_ok_s1;

	// Response register
	logic              out_vld_q;
	logic [DATA_W-1:0] out_byte_q;
	logic [IDX_W-1:0]  out_pos_q;

	logic              acc_req;
	logic              div_start;
	logic [IDX_W-1:0]  div_arg;
	div_res_t          div_res;
	logic              issue;
	logic              row_ok;
	logic              slot_free;
	logic              rsp_load;
	logic              idx_hdr;
	logic              idx_out;

	mbp_div #(
		.DIVISOR (COLUMNS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_arg),
		.res      (div_res)
	);

	// Request decode
	always_comb begin
		acc_req   = req.valid && req.ready;
		idx_out   = (32'(req.out_index) >= OUTPUT_BYTES);
		idx_hdr   = (32'(req.out_index) < HEADER_BYTES);
		div_start = acc_req && (req.req_type == REQ_READ) && !idx_out && !idx_hdr;
		div_arg   = IDX_W'(32'(req.out_index) - HEADER_BYTES);
		issue     = (state_q == ST_GATHER) && (iss_q < 4'd8);
		row_ok    = ((32'(row_base_q) + 32'(iss_q[2:0])) < ROWS);
		slot_free = !out_vld_q || rsp.ready;
		rsp_load  = (state_q == ST_DONE) && slot_free;
		mem_we    = (state_q == ST_WR) && wr_ok_q;
		mem_addr  = (state_q == ST_WR) ? wr_addr_q : addr_q;
	end

	assign req.ready = (state_q == ST_IDLE);

	// Single-port store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= wr_data_q;
		end
		rdata_q <= mem[mem_addr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iss_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			// a new response replaces one taken in the same cycle
			if (rsp_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_req) begin
						if (req.req_type == REQ_WRITE) begin
							state_q <= ST_WR;
						end else if (div_start) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WR: begin
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					iss_q   <= '0;
					state_q <= ST_GATHER;
				end
				ST_GATHER: begin
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// capture request
		if (acc_req) begin
			wr_ok_q   <= (32'(req.src_row) < ROWS) && (32'(req.src_byte) < ROW_BYTES);
			wr_addr_q <= AW'(32'(req.src_row) * ROW_BYTES + 32'(req.src_byte));
			wr_data_q <= req.src_data;
			idx_q     <= req.out_index;
			if (idx_out) begin
				acc_q <= '0;
			end else if (req.out_index == '0) begin
				acc_q <= HEADER_MAGIC;
			end else begin
				acc_q <= '0;
			end
		end

		// band start address and bit lane of the column
		if (state_q == ST_BASE) begin
			row_base_q <= RB_W'({div_res.quot, 3'b000});
			addr_q     <= AW'(32'(div_res.quot) * (8 * ROW_BYTES) + 32'(div_res.rem >> 3));
			bit_q      <= div_res.rem[2:0];
			acc_q      <= '0;
		end

		// walk down the band, one row per read
		if (issue) begin
			addr_q <= AW'(32'(addr_q) + ROW_BYTES);
		end
		rd_r_s1  <= iss_q[2:0];
		rd_ok_s1 <= row_ok;
		if (rd_vld_s1) begin
			acc_q[rd_r_s1] <= rd_ok_s1 & rdata_q[bit_q];
		end

		// load response
		if (rsp_load) begin
			out_byte_q <= acc_q;
			out_pos_q  <= idx_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.out_byte     = out_byte_q;
	assign rsp.out_position = out_pos_q;

endmodule

### rtl/mbp_div.sv
// Constant divider that splits a message offset into band and column by reciprocal multiply.
`timescale 1ns / 1ps

module mbp_div #(
	parameter int DIVISOR = 160
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mbp_pkg::IDX_W-1:0] dividend,
	output mbp_pkg::div_res_t        res
);
	import mbp_pkg::*;

	// floor(n / DIVISOR) equals (n * RECIP) >> SHIFT for every IDX_W-bit n
	localparam int SHIFT   = IDX_W + $clog2(DIVISOR);
	localparam int RECIP   = ((2 ** SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int RECIP_W = IDX_W + 2;
	localparam int PROD_W  = IDX_W + RECIP_W;

	logic              vld_s1;
	logic              vld_s2;
	logic              done_q;
	logic [IDX_W-1:0]  num_s1;
	logic [IDX_W-1:0]  num_s2;
	logic [IDX_W-1:0]  quo_s2;
	logic [IDX_W-1:0]  quo_q;
	logic [IDX_W-1:0]  rem_q;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] back;
	logic [IDX_W-1:0]  quo_nxt;
	logic [IDX_W-1:0]  rem_nxt;

	// Quotient in the first stage, remainder in the second
	always_comb begin
		prod    = PROD_W'(num_s1) * PROD_W'(RECIP);
		quo_nxt = IDX_W'(prod >> SHIFT);
		back    = PROD_W'(quo_s2) * PROD_W'(DIVISOR);
		rem_nxt = num_s2 - IDX_W'(back);
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	// Operand and result registers, held until the next start
	always_ff @(posedge clk) begin
		if (start) begin
			num_s1 <= dividend;
		end
		if (vld_s1) begin
			quo_s2 <= quo_nxt;
			num_s2 <= num_s1;
		end
		if (vld_s2) begin
			quo_q <= quo_s2;
			rem_q <= rem_nxt;
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule
